// ===== hdl/sku_pkg.sv =====
`default_nettype none

package sku_pkg;

    localparam int DEPTH     = 128;
    localparam int KEY_WIDTH = 16;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD_DEPTH = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SEARCH,
        S_SHIFT,
        S_RESP
    } state_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] read_key;
        logic [7:0]  occupancy;
    } result_t;

    typedef struct packed {
        logic                 rd_en;
        logic [ADDR_W-1:0]    rd_addr;
        logic                 wr_en;
        logic [ADDR_W-1:0]    wr_addr;
        logic [KEY_WIDTH-1:0] wr_data;
    } ram_req_t;

endpackage

`default_nettype wire

// ===== hdl/sku_ram.sv =====
`default_nettype none

module sku_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sku_seq.sv =====
`default_nettype none

module sku_seq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire logic [1:0]                    req_type,
    input  wire logic [15:0]                   key,
    input  wire logic [6:0]                    depth_from_top,
    output sku_pkg::ram_req_t                  ram_req,
    input  wire logic [sku_pkg::KEY_WIDTH-1:0] ram_rdata,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output sku_pkg::result_t                   res
);

    localparam int AW = sku_pkg::ADDR_W;
    localparam int CW = sku_pkg::CNT_W;

    sku_pkg::state_t              state_reg, state_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [sku_pkg::KEY_WIDTH-1:0] key_reg, key_next;
    logic [AW-1:0]                cmp_addr_reg, cmp_addr_next;
    logic [AW-1:0]                wptr_reg, wptr_next;
    sku_pkg::status_t             status_reg, status_next;
    logic [15:0]                  rkey_reg, rkey_next;

    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] rd_idx;
    logic          match;
    logic          cmp_last;
    logic          found_top;
    logic          shift_last;
    logic          full;
    logic          empty;
    logic          bad_depth;

    assign cnt_m1     = cnt_reg - CW'(1);
    assign rd_idx     = cnt_m1 - CW'(depth_from_top);
    assign match      = ram_rdata == key_reg;
    assign cmp_last   = cmp_addr_reg == '0;
    assign found_top  = CW'(cmp_addr_reg) == cnt_m1;
    assign shift_last = (CW'(wptr_reg) + CW'(1)) == cnt_m1;
    assign full       = 32'(cnt_reg) >= sku_pkg::DEPTH;
    assign empty      = cnt_reg == '0;
    assign bad_depth  = 32'(depth_from_top) >= 32'(cnt_reg);

    // next state and datapath
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        key_next      = key_reg;
        cmp_addr_next = cmp_addr_reg;
        wptr_next     = wptr_reg;
        status_next   = status_reg;
        rkey_next     = rkey_reg;
        unique case (state_reg)
            sku_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    key_next    = key[sku_pkg::KEY_WIDTH-1:0];
                    rkey_next   = '0;
                    status_next = sku_pkg::ST_OK;
                    state_next  = sku_pkg::S_RESP;
                    unique case (sku_pkg::req_t'(req_type))
                        sku_pkg::REQ_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = sku_pkg::ST_FULL;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        sku_pkg::REQ_REMOVE:
                        begin
                            if (empty)
                            begin
                                status_next = sku_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmp_addr_next = cnt_m1[AW-1:0];
                                state_next    = sku_pkg::S_SEARCH;
                            end
                        end
                        sku_pkg::REQ_READ:
                        begin
                            if (empty)
                            begin
                                status_next = sku_pkg::ST_EMPTY;
                            end
                            else if (bad_depth)
                            begin
                                status_next = sku_pkg::ST_BAD_DEPTH;
                            end
                            else
                            begin
                                state_next = sku_pkg::S_READ;
                            end
                        end
                        sku_pkg::REQ_NONE:
                        begin
                            status_next = sku_pkg::ST_OK;
                        end
                    endcase
                end
            end
            sku_pkg::S_READ:
            begin
                rkey_next  = 16'(ram_rdata);
                state_next = sku_pkg::S_RESP;
            end
            sku_pkg::S_SEARCH:
            begin
                if (match)
                begin
                    if (found_top)
                    begin
                        cnt_next   = cnt_m1;
                        state_next = sku_pkg::S_RESP;
                    end
                    else
                    begin
                        wptr_next  = cmp_addr_reg;
                        state_next = sku_pkg::S_SHIFT;
                    end
                end
                else if (cmp_last)
                begin
                    status_next = sku_pkg::ST_NOT_FOUND;
                    state_next  = sku_pkg::S_RESP;
                end
                else
                begin
                    cmp_addr_next = cmp_addr_reg - AW'(1);
                end
            end
            sku_pkg::S_SHIFT:
            begin
                if (shift_last)
                begin
                    cnt_next   = cnt_m1;
                    state_next = sku_pkg::S_RESP;
                end
                else
                begin
                    wptr_next = wptr_reg + AW'(1);
                end
            end
            sku_pkg::S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = sku_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sku_pkg::S_IDLE;
            end
        endcase
    end

    // handshakes and memory accesses
    always_comb
    begin
        req_ready     = state_reg == sku_pkg::S_IDLE;
        res_valid     = state_reg == sku_pkg::S_RESP;
        res.status    = status_reg;
        res.read_key  = rkey_reg;
        res.occupancy = 8'(cnt_reg);
        ram_req       = '0;
        unique case (state_reg)
            sku_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    if (sku_pkg::req_t'(req_type) == sku_pkg::REQ_PUSH && !full)
                    begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = cnt_reg[AW-1:0];
                        ram_req.wr_data = key[sku_pkg::KEY_WIDTH-1:0];
                    end
                    if (sku_pkg::req_t'(req_type) == sku_pkg::REQ_REMOVE && !empty)
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = cnt_m1[AW-1:0];
                    end
                    if (sku_pkg::req_t'(req_type) == sku_pkg::REQ_READ && !empty
                        && !bad_depth)
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = rd_idx[AW-1:0];
                    end
                end
            end
            sku_pkg::S_SEARCH:
            begin
                if (match && !found_top)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = cmp_addr_reg + AW'(1);
                end
                else if (!match && !cmp_last)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = cmp_addr_reg - AW'(1);
                end
            end
            sku_pkg::S_SHIFT:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = wptr_reg;
                ram_req.wr_data = ram_rdata;
                if (!shift_last)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = wptr_reg + AW'(2);
                end
            end
            sku_pkg::S_READ,
            sku_pkg::S_RESP:
            begin
                ram_req = '0;
            end
            default:
            begin
                ram_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sku_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        cmp_addr_reg <= cmp_addr_next;
        wptr_reg     <= wptr_next;
        status_reg   <= status_next;
        rkey_reg     <= rkey_next;
    end

endmodule

`default_nettype wire

// ===== hdl/stack_with_keyed_removal_unit.sv =====
`default_nettype none

// Bounded stack of keys with removal by key. Each request beat yields one
// result beat carrying a status, the key read (zero unless a read succeeds)
// and the occupancy after the request. The entries sit in one RAM with a
// registered read port; the sequencer works on one request at a time. A push,
// a request refused at once (full, empty, depth past the bottom) or the unused
// request code goes from accept straight to the result state; a read first
// passes through a RAM read state. A remove scans the RAM from the top, one
// entry per cycle, then shifts the entries above the match down one place,
// one entry per cycle. A remove with no match scans every held entry. The
// worst case is a match at the bottom of a full stack: DEPTH entries scanned
// and DEPTH - 1 shifted. A new request is taken as soon as the previous
// result has moved into the output register, even while that result still
// waits for the consumer. The RAM needs no clearing after reset: only
// entries below the occupancy are ever read.
module stack_with_keyed_removal_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [15:0] key,
    input  wire logic [6:0]  depth_from_top,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic [2:0]       status,
    output logic [15:0]      read_key,
    output logic [7:0]       occupancy
);

    sku_pkg::ram_req_t                ram_req;
    logic [sku_pkg::KEY_WIDTH-1:0]    ram_rdata;
    logic                             seq_valid;
    logic                             seq_ready;
    sku_pkg::result_t                 seq_res;

    logic                             out_valid_reg, out_valid_next;
    sku_pkg::result_t                 out_res_reg, out_res_next;

    sku_ram #(
        .WIDTH (sku_pkg::KEY_WIDTH),
        .DEPTH (sku_pkg::DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rdata)
    );

    sku_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_type       (req_type),
        .key            (key),
        .depth_from_top (depth_from_top),
        .ram_req        (ram_req),
        .ram_rdata      (ram_rdata),
        .res_valid      (seq_valid),
        .res_ready      (seq_ready),
        .res            (seq_res)
    );

    // Output register: take a new result whenever the slot is empty or the
    // held beat leaves in this cycle.
    assign seq_ready = !out_valid_reg || res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (seq_ready)
        begin
            out_valid_next = seq_valid;
            if (seq_valid)
            begin
                out_res_next = seq_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the payload while a beat waits
    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign res_valid = out_valid_reg;
    assign status    = 3'(out_res_reg.status);
    assign read_key  = out_res_reg.read_key;
    assign occupancy = out_res_reg.occupancy;

endmodule

`default_nettype wire
